[hw/rtl/motor_command_frame_parser_top_defines.svh]
// assertion macros shared by the motor command frame parser checkers
`ifndef MOTOR_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH

// checked only outside reset
`define MCFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked during reset as well
`define MCFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/mcfp_pkg.sv]
// types and constants for the motor command frame parser
package mcfp_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } mcfp_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] speed_front_right;
    logic signed [31:0] speed_front_left;
    logic signed [31:0] speed_rear_right;
    logic signed [31:0] speed_rear_left;
  } mcfp_out_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  consecutive_threshold;
  } mcfp_cfg_t;

  typedef enum logic [1:0] {
    FP_SPACE,
    FP_SIGN,
    FP_DIGITS,
    FP_DONE
  } mcfp_phase_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] RK_SPEEDS = 2'd0;
  localparam logic [1:0] RK_STOP   = 2'd1;
  localparam logic [1:0] RK_REPORT = 2'd2;

  localparam logic [7:0] CFG_TIMEOUT_MS  = 8'd0;
  localparam logic [7:0] CFG_CONSEC_THR  = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
  localparam logic [7:0]  CONSEC_RESET   = 8'd10;

  localparam logic [7:0] CH_OPEN    = 8'h3C; // '<'
  localparam logic [7:0] CH_CLOSE   = 8'h3E; // '>'
  localparam logic [7:0] CH_REPORT  = 8'h72; // 'r'
  localparam logic [7:0] CH_COMMA   = 8'h2C; // ','
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] DIG_LIMIT = 32'd214748365;
  localparam logic [16:0] MS_MAX    = 17'h1FFFF;
  localparam logic [7:0]  CONSEC_MAX = 8'hFF;

endpackage

[hw/rtl/mcfp_pipe_reg.sv]
// one-entry valid/ready register stage
module mcfp_pipe_reg #(
  parameter int WIDTH = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [WIDTH-1:0] up_data,
  output logic             down_valid,
  input  logic             down_ready,
  output logic [WIDTH-1:0] down_data
);

  logic             full;
  logic [WIDTH-1:0] data;

  // refill in the same cycle the held item drains
  assign up_ready   = !full || down_ready;
  assign down_valid = full;
  assign down_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (up_valid && up_ready) begin
      full <= 1'b1;
    end else if (down_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= up_data;
    end
  end

endmodule

[hw/rtl/mcfp_cfg_regs.sv]
// configuration registers: watchdog timeout and line threshold
module mcfp_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [7:0]         wr_index,
  input  logic [15:0]        wr_data,
  output mcfp_pkg::mcfp_cfg_t cfg
);
  import mcfp_pkg::*;

  logic [15:0] timeout_ms;
  logic [7:0]  consecutive_threshold;

  assign cfg.timeout_ms            = timeout_ms;
  assign cfg.consecutive_threshold = consecutive_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms            <= TIMEOUT_RESET;
      consecutive_threshold <= CONSEC_RESET;
    end else if (wr_en) begin
      if (wr_index == CFG_TIMEOUT_MS) begin
        timeout_ms <= wr_data;
      end else if (wr_index == CFG_CONSEC_THR) begin
        consecutive_threshold <= wr_data[7:0];
      end
    end
  end

endmodule

[hw/rtl/mcfp_parse_core.sv]
// line, frame and field parser with watchdog and line counter
module mcfp_parse_core #(
  parameter int NUM_MOTORS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  mcfp_pkg::mcfp_in_t  item,
  input  mcfp_pkg::mcfp_cfg_t cfg,
  output logic                emit,
  output mcfp_pkg::mcfp_out_t result
);
  import mcfp_pkg::*;

  localparam int SW = $clog2(NUM_MOTORS + 1);
  localparam logic [SW-1:0] SLOT_END = SW'(NUM_MOTORS);

  logic              in_frame, in_frame_next;
  logic              line_finished, line_finished_next;
  logic              line_had_data, line_had_data_next;
  logic [SW-1:0]     slot_index, slot_index_next;
  logic [31:0]       field_accumulator, field_accumulator_next;
  logic              field_negative, field_negative_next;
  mcfp_phase_t       field_phase, field_phase_next;
  logic [7:0]        consecutive_lines, consecutive_lines_next;
  logic [16:0]       ms_since_command, ms_since_command_next;
  logic [31:0]       speed_slots [NUM_MOTORS];

  logic [7:0]  c;
  logic        is_digit;
  logic        is_space;
  logic [31:0] acc_mul;
  logic [31:0] acc_digit;
  logic [31:0] field_value;
  logic [16:0] ms_inc;
  logic        slot_we;
  logic        slot_clear;
  logic        emit_raw;
  logic [1:0]  kind;
  logic [31:0] speed_out [4];

  assign c        = item.data_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

  // m * 10 + digit, only used while m is below the limit so nothing is lost
  assign acc_mul   = {field_accumulator[28:0], 3'b000} + {field_accumulator[30:0], 1'b0}
                     + {28'd0, c[3:0]};
  assign acc_digit = (field_accumulator >= DIG_LIMIT) ? MAG_LIMIT :
                     ((acc_mul > MAG_LIMIT) ? MAG_LIMIT : acc_mul);

  assign field_value = field_negative ? (32'd0 - field_accumulator) :
                       ((field_accumulator > POS_MAX) ? POS_MAX : field_accumulator);

  assign ms_inc = (ms_since_command < MS_MAX) ? (ms_since_command + 17'd1) : ms_since_command;

  always_comb begin
    in_frame_next          = in_frame;
    line_finished_next     = line_finished;
    line_had_data_next     = line_had_data;
    slot_index_next        = slot_index;
    field_accumulator_next = field_accumulator;
    field_negative_next    = field_negative;
    field_phase_next       = field_phase;
    consecutive_lines_next = consecutive_lines;
    ms_since_command_next  = ms_since_command;
    slot_we                = 1'b0;
    slot_clear             = 1'b0;
    emit_raw               = 1'b0;
    kind                   = RK_SPEEDS;

    if (item.operation == OP_TICK) begin
      ms_since_command_next = ms_inc;
      if (ms_inc > {1'b0, cfg.timeout_ms}) begin
        consecutive_lines_next = 8'd0;
        emit_raw               = 1'b1;
        kind                   = RK_STOP;
      end
    end else if (c == CH_NEWLINE) begin
      if (line_had_data) begin
        ms_since_command_next = 17'd0;
        if (consecutive_lines != CONSEC_MAX) begin
          consecutive_lines_next = consecutive_lines + 8'd1;
        end
      end
      in_frame_next          = 1'b0;
      line_finished_next     = 1'b0;
      line_had_data_next     = 1'b0;
      slot_index_next        = '0;
      field_accumulator_next = 32'd0;
      field_negative_next    = 1'b0;
      field_phase_next       = FP_SPACE;
      slot_clear             = 1'b1;
    end else if (!line_finished) begin
      if (c == CH_OPEN) begin
        in_frame_next = 1'b1;
      end else if (c == CH_CLOSE) begin
        in_frame_next      = 1'b0;
        line_finished_next = 1'b1;
        if (consecutive_lines > cfg.consecutive_threshold) begin
          consecutive_lines_next = cfg.consecutive_threshold;
          emit_raw               = 1'b1;
          kind                   = RK_SPEEDS;
        end
      end else if (in_frame) begin
        if (c == CH_REPORT) begin
          in_frame_next      = 1'b0;
          line_finished_next = 1'b1;
          emit_raw           = 1'b1;
          kind               = RK_REPORT;
        end else if (c == CH_COMMA) begin
          // fields past the last motor are converted and dropped
          if (slot_index < SLOT_END) begin
            slot_we         = 1'b1;
            slot_index_next = slot_index + SW'(1);
          end
          field_accumulator_next = 32'd0;
          field_negative_next    = 1'b0;
          field_phase_next       = FP_SPACE;
        end else begin
          line_had_data_next = 1'b1;
          if (c == CH_NUL) begin
            field_phase_next = FP_DONE;
          end else if (field_phase != FP_DONE) begin
            if (is_digit) begin
              field_phase_next       = FP_DIGITS;
              field_accumulator_next = acc_digit;
            end else if (field_phase == FP_SPACE && is_space) begin
              field_phase_next = FP_SPACE;
            end else if (field_phase == FP_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
              field_negative_next = (c == CH_MINUS);
              field_phase_next    = FP_SIGN;
            end else begin
              field_phase_next = FP_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame          <= 1'b0;
      line_finished     <= 1'b0;
      line_had_data     <= 1'b0;
      slot_index        <= '0;
      field_accumulator <= 32'd0;
      field_negative    <= 1'b0;
      field_phase       <= FP_SPACE;
      consecutive_lines <= 8'd0;
      ms_since_command  <= 17'd0;
    end else if (step) begin
      in_frame          <= in_frame_next;
      line_finished     <= line_finished_next;
      line_had_data     <= line_had_data_next;
      slot_index        <= slot_index_next;
      field_accumulator <= field_accumulator_next;
      field_negative    <= field_negative_next;
      field_phase       <= field_phase_next;
      consecutive_lines <= consecutive_lines_next;
      ms_since_command  <= ms_since_command_next;
    end
  end

  for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (rst) begin
        speed_slots[i] <= 32'd0;
      end else if (step) begin
        if (slot_clear) begin
          speed_slots[i] <= 32'd0;
        end else if (slot_we && slot_index == SW'(i)) begin
          speed_slots[i] <= field_value;
        end
      end
    end
  end

  // slots past the motor count read as zero
  for (genvar j = 0; j < 4; j++) begin : g_out
    if (j < NUM_MOTORS) begin : g_used
      assign speed_out[j] = (kind == RK_SPEEDS) ? speed_slots[j] : 32'd0;
    end else begin : g_unused
      assign speed_out[j] = 32'd0;
    end
  end

  assign emit                     = step && emit_raw;
  assign result.result_kind       = kind;
  assign result.speed_front_right = speed_out[0];
  assign result.speed_front_left  = speed_out[1];
  assign result.speed_rear_right  = speed_out[2];
  assign result.speed_rear_left   = speed_out[3];

endmodule

[hw/rtl/motor_command_frame_parser_top.sv]
// motor command frame parser: serial bytes and ms ticks in, motor commands out
//
// in channel: one item per serial byte (operation 0) or millisecond tick
// (operation 1). out channel: at most one command per item, either the four
// parsed speeds, a stop with zero speeds, or a report request.
// cfg channel: index 0 writes timeout_ms, 1 writes consecutive_threshold;
// cfg_ready is always high and other indexes are dropped.
// an accepted item is held in the input register, parsed once the output
// register can take its command; that command, if any, is registered there.
// throughput: one item per cycle unless the receiver stalls; the parser state
// update is a single multiply-by-ten, add and saturate between the registers.
// a waiting command does not block input while the input register is free,
// and the output register refills in the cycle it is taken.
// when the receiver stalls, the held command stays put and input stops once
// the input register also holds an item.
// reset clears the parser state, the line counter, the watchdog and both
// stage registers, and loads timeout 100 ms and threshold 10.
module motor_command_frame_parser_top #(
  parameter int NUM_MOTORS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcfp_pkg::mcfp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcfp_pkg::mcfp_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import mcfp_pkg::*;

  localparam int IN_W  = $bits(mcfp_in_t);
  localparam int OUT_W = $bits(mcfp_out_t);

  logic            held_valid;
  logic            held_ready;
  logic [IN_W-1:0] held_bits;
  mcfp_in_t        held_item;
  logic            res_valid;
  logic            res_ready;
  mcfp_out_t       res_item;
  logic [OUT_W-1:0] out_bits;
  mcfp_cfg_t       cfg;
  logic            step;

  assign cfg_ready = 1'b1;
  assign held_item = held_bits;
  assign out_data  = out_bits;

  // an item is parsed only when the output register can take its command
  assign step       = held_valid && res_ready;
  assign held_ready = res_ready;

  mcfp_pipe_reg #(.WIDTH(IN_W)) u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .up_data    (in_data),
    .down_valid (held_valid),
    .down_ready (held_ready),
    .down_data  (held_bits)
  );

  mcfp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mcfp_parse_core #(.NUM_MOTORS(NUM_MOTORS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .cfg    (cfg),
    .emit   (res_valid),
    .result (res_item)
  );

  mcfp_pipe_reg #(.WIDTH(OUT_W)) u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (res_valid),
    .up_ready   (res_ready),
    .up_data    (res_item),
    .down_valid (out_valid),
    .down_ready (out_ready),
    .down_data  (out_bits)
  );

endmodule

[hw/rtl/mcfp_checker.sv]
// port-level checks for the motor command frame parser, bound to the top level
`include "motor_command_frame_parser_top_defines.svh"

module mcfp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mcfp_pkg::mcfp_out_t out_data
);
  import mcfp_pkg::*;

  logic stalled;
  logic no_speeds;
  logic speeds_zero;

  assign stalled     = out_valid && !out_ready;
  assign no_speeds   = out_valid && (out_data.result_kind != RK_SPEEDS);
  assign speeds_zero = ({out_data.speed_front_right, out_data.speed_front_left,
                         out_data.speed_rear_right, out_data.speed_rear_left} == '0);

  `MCFP_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_data), "held command changed")
  `MCFP_ASSERT(a_kind_known, out_valid |-> out_data.result_kind <= RK_REPORT, "bad result kind")
  `MCFP_ASSERT(a_zero_speeds, no_speeds |-> speeds_zero, "stop or report with nonzero speed")
  `MCFP_ASSERT(a_no_block, !out_valid |-> in_ready, "input blocked with empty output")
  `MCFP_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "command valid after reset")

endmodule

bind motor_command_frame_parser_top mcfp_checker u_mcfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
